>>> rtl/mbe_pkg.sv
`default_nettype none

package mbe_pkg;

    // Fixed-point format of c and z: 5 integer bits and FRAC_BITS fraction bits.
    localparam int FRAC_BITS = 27;
    localparam int Z_W       = FRAC_BITS + 5;
    // Quotient bits produced by the coordinate divider, one per cell.
    localparam int MAP_STEPS = FRAC_BITS + 4;

    localparam int PIX_W      = 12;
    localparam int DIM_W      = 13;
    localparam int LIMIT_W    = 16;
    localparam int SHADE_W    = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT    = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_ITERATION_LIMIT = CFG_IDX_W'(2);

    localparam logic [DIM_W-1:0]   WIDTH_RESET  = DIM_W'(640);
    localparam logic [DIM_W-1:0]   HEIGHT_RESET = DIM_W'(480);
    localparam logic [LIMIT_W-1:0] LIMIT_RESET  = LIMIT_W'(256);

    localparam logic [Z_W-1:0] Z_MAX = {1'b0, {(Z_W-1){1'b1}}};
    localparam logic [Z_W-1:0] Z_MIN = {1'b1, {(Z_W-1){1'b0}}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAP_IM,
        ST_MAP_WAIT,
        ST_ITER,
        ST_SHADE
    } t_state;

    typedef enum logic [1:0] {
        ES_IDLE,
        ES_MUL,
        ES_UPD
    } t_esc_state;

    typedef struct packed {
        logic done;
        logic limit_hit;
    } t_esc_status;

    typedef struct packed {
        logic is_im;
        logic neg;
        logic sat;
    } t_map_tag;

endpackage

`default_nettype wire

>>> rtl/mbe_div_cell.sv
`default_nettype none

// One restoring division step: shift in the next dividend bit, subtract the
// divisor when it fits, and hand everything to the next cell.
module mbe_div_cell #(
    parameter int REM_W = 13,
    parameter int STEPS = 31,
    parameter int TAG_W = 3
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [REM_W-1:0] i_rem,
    input  logic [STEPS-1:0] i_feed,
    input  logic [STEPS-1:0] i_quo,
    input  logic [REM_W-1:0] i_div,
    input  logic [TAG_W-1:0] i_tag,
    output logic             o_valid,
    output logic [REM_W-1:0] o_rem,
    output logic [STEPS-1:0] o_feed,
    output logic [STEPS-1:0] o_quo,
    output logic [REM_W-1:0] o_div,
    output logic [TAG_W-1:0] o_tag
);

    logic [REM_W:0]   w_trial;
    logic [REM_W:0]   w_diff;
    logic             w_take;
    logic             r_valid;
    logic [REM_W-1:0] r_rem;
    logic [STEPS-1:0] r_feed;
    logic [STEPS-1:0] r_quo;
    logic [REM_W-1:0] r_div;
    logic [TAG_W-1:0] r_tag;

    assign w_trial = {i_rem, i_feed[STEPS-1]};
    assign w_diff  = w_trial - {1'b0, i_div};
    assign w_take  = (w_trial >= {1'b0, i_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= w_take ? w_diff[REM_W-1:0] : w_trial[REM_W-1:0];
        r_feed <= {i_feed[STEPS-2:0], 1'b0};
        r_quo  <= {i_quo[STEPS-2:0], w_take};
        r_div  <= i_div;
        r_tag  <= i_tag;
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_feed  = r_feed;
    assign o_quo   = r_quo;
    assign o_div   = r_div;
    assign o_tag   = r_tag;

endmodule

`default_nettype wire

>>> rtl/mbe_div_chain.sv
`default_nettype none

// A row of division cells. A new division may enter every cycle; the
// quotient is formed MSB first and leaves the last cell as a whole.
module mbe_div_chain #(
    parameter int REM_W = 13,
    parameter int STEPS = 31,
    parameter int TAG_W = 3
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [REM_W-1:0] i_rem,
    input  logic [STEPS-1:0] i_feed,
    input  logic [REM_W-1:0] i_div,
    input  logic [TAG_W-1:0] i_tag,
    output logic             o_valid,
    output logic [STEPS-1:0] o_quo,
    output logic [TAG_W-1:0] o_tag
);

    logic             w_valid [0:STEPS];
    logic [STEPS-1:0] w_quo   [0:STEPS];
    logic [TAG_W-1:0] w_tag   [0:STEPS];
    logic [REM_W-1:0] w_rem   [0:STEPS-1];
    logic [STEPS-1:0] w_feed  [0:STEPS-1];
    logic [REM_W-1:0] w_div   [0:STEPS-1];

    assign w_valid[0] = i_valid;
    assign w_quo[0]   = '0;
    assign w_tag[0]   = i_tag;
    assign w_rem[0]   = i_rem;
    assign w_feed[0]  = i_feed;
    assign w_div[0]   = i_div;

    for (genvar k = 0; k < STEPS; k++) begin : g_cell
        if (k < STEPS - 1) begin : g_mid
            mbe_div_cell #(
                .REM_W (REM_W),
                .STEPS (STEPS),
                .TAG_W (TAG_W)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_valid (w_valid[k]),
                .i_rem   (w_rem[k]),
                .i_feed  (w_feed[k]),
                .i_quo   (w_quo[k]),
                .i_div   (w_div[k]),
                .i_tag   (w_tag[k]),
                .o_valid (w_valid[k+1]),
                .o_rem   (w_rem[k+1]),
                .o_feed  (w_feed[k+1]),
                .o_quo   (w_quo[k+1]),
                .o_div   (w_div[k+1]),
                .o_tag   (w_tag[k+1])
            );
        end else begin : g_last
            mbe_div_cell #(
                .REM_W (REM_W),
                .STEPS (STEPS),
                .TAG_W (TAG_W)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_valid (w_valid[k]),
                .i_rem   (w_rem[k]),
                .i_feed  (w_feed[k]),
                .i_quo   (w_quo[k]),
                .i_div   (w_div[k]),
                .i_tag   (w_tag[k]),
                .o_valid (w_valid[k+1]),
                .o_rem   (),
                .o_feed  (),
                .o_quo   (w_quo[k+1]),
                .o_div   (),
                .o_tag   (w_tag[k+1])
            );
        end
    end

    assign o_valid = w_valid[STEPS];
    assign o_quo   = w_quo[STEPS];
    assign o_tag   = w_tag[STEPS];

endmodule

`default_nettype wire

>>> rtl/mbe_escape_core.sv
`default_nettype none

// Escape-time iteration: each complex step runs through ES_MUL, forming the
// three products, then ES_UPD, doing the radius test and the new z.
module mbe_escape_core #(
    parameter int COUNT_BITS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [mbe_pkg::Z_W-1:0]   i_cr,
    input  logic [mbe_pkg::Z_W-1:0]   i_ci,
    input  logic [COUNT_BITS-1:0]     i_limit,
    output mbe_pkg::t_esc_status      o_status,
    output logic [COUNT_BITS-1:0]     o_count
);

    import mbe_pkg::*;

    localparam int PROD_W = 2 * Z_W;
    localparam int ACC_W  = PROD_W + 2;
    localparam logic [PROD_W:0] RADIUS_SQ = (PROD_W + 1)'(1) << (2 * FRAC_BITS + 2);

    t_esc_state        r_state;
    t_esc_state        n_state;
    logic [Z_W-1:0]    r_zr;
    logic [Z_W-1:0]    r_zi;
    logic [COUNT_BITS-1:0] r_count;
    logic [PROD_W-1:0] r_sq_re;
    logic [PROD_W-1:0] r_sq_im;
    logic [PROD_W-1:0] r_cross;
    logic              r_cross_neg;

    logic [Z_W-1:0]    w_mag_re;
    logic [Z_W-1:0]    w_mag_im;
    logic [PROD_W:0]   w_radius;
    logic              w_within;
    logic              w_continue;
    logic [ACC_W-1:0]  w_cr_scaled;
    logic [ACC_W-1:0]  w_ci_scaled;
    logic [ACC_W-1:0]  w_re_acc;
    logic [ACC_W-1:0]  w_im_acc;
    logic [ACC_W-1:0]  w_re_sh;
    logic [ACC_W-1:0]  w_im_sh;
    logic [Z_W-1:0]    n_zr;
    logic [Z_W-1:0]    n_zi;

    function automatic logic [Z_W-1:0] f_clamp(input logic [ACC_W-1:0] v);
        logic [ACC_W-Z_W:0] hi;
        hi = v[ACC_W-1:Z_W-1];
        if (hi == {(ACC_W-Z_W+1){1'b0}} || hi == {(ACC_W-Z_W+1){1'b1}}) begin
            return v[Z_W-1:0];
        end else if (v[ACC_W-1]) begin
            return Z_MIN;
        end else begin
            return Z_MAX;
        end
    endfunction

    assign w_mag_re = r_zr[Z_W-1] ? (~r_zr + Z_W'(1)) : r_zr;
    assign w_mag_im = r_zi[Z_W-1] ? (~r_zi + Z_W'(1)) : r_zi;

    assign w_radius   = {1'b0, r_sq_re} + {1'b0, r_sq_im};
    assign w_within   = (w_radius <= RADIUS_SQ);
    assign w_continue = (r_count < i_limit) && w_within;

    // Adding c scaled up before the shift gives floor(p / 2^F) + c exactly.
    assign w_cr_scaled = {{(ACC_W-Z_W-FRAC_BITS){i_cr[Z_W-1]}}, i_cr, {FRAC_BITS{1'b0}}};
    assign w_ci_scaled = {{(ACC_W-Z_W-FRAC_BITS+1){i_ci[Z_W-1]}}, i_ci,
                          {(FRAC_BITS-1){1'b0}}};
    assign w_re_acc = {2'b00, r_sq_re} - {2'b00, r_sq_im} + w_cr_scaled;
    assign w_im_acc = r_cross_neg ? (w_ci_scaled - {2'b00, r_cross})
                                  : (w_ci_scaled + {2'b00, r_cross});
    assign w_re_sh  = $signed(w_re_acc) >>> FRAC_BITS;
    assign w_im_sh  = $signed(w_im_acc) >>> (FRAC_BITS - 1);
    assign n_zr     = f_clamp(w_re_sh);
    assign n_zi     = f_clamp(w_im_sh);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ES_IDLE: begin
                if (i_start) n_state = ES_MUL;
            end
            ES_MUL: begin
                n_state = ES_UPD;
            end
            ES_UPD: begin
                if (w_continue) n_state = ES_MUL;
                else            n_state = ES_IDLE;
            end
            default: begin
                n_state = ES_IDLE;
            end
        endcase
    end

    always_comb begin
        o_status.done      = (r_state == ES_UPD) && !w_continue;
        o_status.limit_hit = !(r_count < i_limit);
        o_count            = r_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ES_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ES_IDLE && i_start) begin
            r_zr    <= '0;
            r_zi    <= '0;
            r_count <= '0;
        end else if (r_state == ES_UPD && w_continue) begin
            r_zr    <= n_zr;
            r_zi    <= n_zi;
            r_count <= r_count + COUNT_BITS'(1);
        end
        if (r_state == ES_MUL) begin
            r_sq_re     <= w_mag_re * w_mag_re;
            r_sq_im     <= w_mag_im * w_mag_im;
            r_cross     <= w_mag_re * w_mag_im;
            r_cross_neg <= r_zr[Z_W-1] ^ r_zi[Z_W-1];
        end
    end

endmodule

`default_nettype wire

>>> rtl/mandelbrot_escape_time_pixel.sv
// Escape-time shade of one Mandelbrot pixel. Raise start while busy is low
// and the pixel's column and row are on the input ports; that edge is the
// transfer of the pixel. The column and row are first mapped to c through a
// row of restoring-division cells (one quotient bit per cell, real part
// first and imaginary part in the cycle after), then z = z*z + c runs from
// zero in the escape core, each step forming the three products and then
// doing the radius test and the new z, and finally 255*count/limit passes
// through a second, eight-cell division row. The time from the transfer
// until the next pixel can be taken grows with the number of steps that
// ran. The shade is shown on o_shade for exactly one cycle with
// o_shade_valid high, and busy is already low in that cycle. There is no
// back-pressure: the receiver must take the shade in the cycle in which it
// appears. Configuration registers are written through i_cfg_we,
// i_cfg_index and i_cfg_data and take effect at once; they must only be
// written while busy is low. Index 0 is the image width, 1 the image height
// and 2 the iteration limit; other indexes are ignored. Only the low 13
// bits of a width or height are kept; zero acts as one and a value above
// MAX_DIMENSION acts as MAX_DIMENSION; a limit above the counter range acts
// as the largest count.
`default_nettype none

module mandelbrot_escape_time_pixel #(
    parameter int MAX_DIMENSION = 4096,
    parameter int COUNT_BITS    = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [mbe_pkg::PIX_W-1:0]        i_pixel_column,
    input  logic [mbe_pkg::PIX_W-1:0]        i_pixel_row,
    output logic [mbe_pkg::SHADE_W-1:0]      o_shade,
    output logic                             o_shade_valid,
    input  logic                             i_cfg_we,
    input  logic [mbe_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [mbe_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    import mbe_pkg::*;

    // The dimension clamp can only bite when the cap is below the largest
    // value the register holds.
    localparam int DIM_MAX_REG = (1 << DIM_W) - 1;
    localparam int DIM_CAP_INT = (MAX_DIMENSION < DIM_MAX_REG) ? MAX_DIMENSION : DIM_MAX_REG;
    localparam logic [DIM_W-1:0] DIM_CAP = DIM_W'(DIM_CAP_INT);

    localparam int LIM_W = (COUNT_BITS > LIMIT_W) ? COUNT_BITS : LIMIT_W;
    localparam logic [LIM_W-1:0] LIM_CAP = LIM_W'({COUNT_BITS{1'b1}});

    localparam int NUM_W = DIM_W + 2;
    localparam int SCL_W = COUNT_BITS + SHADE_W;

    // Configuration registers.
    logic [DIM_W-1:0]   r_image_width;
    logic [DIM_W-1:0]   r_image_height;
    logic [LIMIT_W-1:0] r_iteration_limit;

    t_state r_state;
    t_state n_state;

    logic [PIX_W-1:0]   r_row;
    logic [Z_W-1:0]     r_cr;
    logic [Z_W-1:0]     r_ci;
    logic [SHADE_W-1:0] r_shade;
    logic               r_shade_valid;

    // Coordinate preparation for the division row.
    logic [PIX_W-1:0]   w_pix;
    logic [DIM_W-1:0]   w_dim_raw;
    logic               w_is_im;
    logic [DIM_W-1:0]   w_dim;
    logic [NUM_W-1:0]   w_t;
    logic               w_neg;
    logic [NUM_W-1:0]   w_abs;
    logic [NUM_W-1:0]   w_num;
    logic               w_sat;
    t_map_tag           w_map_in_tag;
    logic               w_map_in_valid;

    logic               w_map_valid;
    logic [MAP_STEPS-1:0] w_map_quo;
    t_map_tag           w_map_tag;
    logic [Z_W-1:0]     w_map_mag;
    logic [Z_W-1:0]     w_map_val;

    logic [LIM_W-1:0]      w_lim_wide;
    logic [COUNT_BITS-1:0] w_limit;
    logic                  w_core_start;
    t_esc_status           w_esc_status;
    logic [COUNT_BITS-1:0] w_count;

    logic [SCL_W-1:0]   w_scaled;
    logic               w_sh_in_valid;
    logic               w_sh_valid;
    logic [SHADE_W-1:0] w_sh_quo;
    logic               w_sh_inside;

    // Configuration writes land immediately; unknown indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width     <= WIDTH_RESET;
            r_image_height    <= HEIGHT_RESET;
            r_iteration_limit <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_IMAGE_WIDTH:     r_image_width     <= i_cfg_data[DIM_W-1:0];
                CFG_IMAGE_HEIGHT:    r_image_height    <= i_cfg_data[DIM_W-1:0];
                CFG_ITERATION_LIMIT: r_iteration_limit <= i_cfg_data[LIMIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // The column enters the division row in the transfer cycle, straight
    // from the ports; the row follows in the next cycle from its register.
    always_comb begin
        if (r_state == ST_IDLE) begin
            w_pix     = i_pixel_column;
            w_dim_raw = r_image_width;
            w_is_im   = 1'b0;
        end else begin
            w_pix     = r_row;
            w_dim_raw = r_image_height;
            w_is_im   = 1'b1;
        end
    end

    // c = (2p - d) * 2 / d. The magnitude 2|2p - d| is divided by d with
    // FRAC_BITS + 4 quotient bits; when it reaches 16 d the result would not
    // fit and saturates instead. Below that bound the top bits of the
    // dividend are already smaller than d and seed the remainder.
    assign w_dim = (w_dim_raw == '0)     ? DIM_W'(1) :
                   (w_dim_raw > DIM_CAP) ? DIM_CAP   : w_dim_raw;
    assign w_t   = {2'b00, w_pix, 1'b0} - {2'b00, w_dim};
    assign w_neg = w_t[NUM_W-1];
    assign w_abs = w_neg ? (~w_t + NUM_W'(1)) : w_t;
    assign w_num = {w_abs[NUM_W-2:0], 1'b0};
    assign w_sat = ({2'b00, w_num} >= {w_dim, 4'b0000});

    assign w_map_in_tag.is_im = w_is_im;
    assign w_map_in_tag.neg   = w_neg;
    assign w_map_in_tag.sat   = w_sat;

    mbe_div_chain #(
        .REM_W (DIM_W),
        .STEPS (MAP_STEPS),
        .TAG_W ($bits(t_map_tag))
    ) u_map_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_map_in_valid),
        .i_rem   (DIM_W'(w_num[NUM_W-1:4])),
        .i_feed  ({w_num[3:0], {FRAC_BITS{1'b0}}}),
        .i_div   (w_dim),
        .i_tag   (w_map_in_tag),
        .o_valid (w_map_valid),
        .o_quo   (w_map_quo),
        .o_tag   (w_map_tag)
    );

    assign w_map_mag = {1'b0, w_map_tag.sat ? {MAP_STEPS{1'b1}} : w_map_quo};
    assign w_map_val = w_map_tag.neg ? (~w_map_mag + Z_W'(1)) : w_map_mag;

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE) begin
            r_row <= i_pixel_row;
        end
        if (w_map_valid) begin
            if (w_map_tag.is_im) r_ci <= w_map_val;
            else                 r_cr <= w_map_val;
        end
    end

    // The limit is held to what the step counter can reach.
    assign w_lim_wide = LIM_W'(r_iteration_limit);
    assign w_limit    = (w_lim_wide > LIM_CAP) ? COUNT_BITS'(LIM_CAP)
                                               : COUNT_BITS'(w_lim_wide);

    mbe_escape_core #(
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_core_start),
        .i_cr     (r_cr),
        .i_ci     (r_ci),
        .i_limit  (w_limit),
        .o_status (w_esc_status),
        .o_count  (w_count)
    );

    // Shade = floor(255 n / limit). For an escaped point n is below the
    // limit, so the quotient fits in eight bits and the upper part of 255 n
    // is already smaller than the limit. A point that used up the limit is
    // flagged through the tag and shaded zero, which also covers a zero limit.
    assign w_scaled = {w_count, {SHADE_W{1'b0}}} - {{SHADE_W{1'b0}}, w_count};

    mbe_div_chain #(
        .REM_W (COUNT_BITS),
        .STEPS (SHADE_W),
        .TAG_W (1)
    ) u_shade_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_sh_in_valid),
        .i_rem   (w_scaled[SCL_W-1:SHADE_W]),
        .i_feed  (w_scaled[SHADE_W-1:0]),
        .i_div   (w_limit),
        .i_tag   (w_esc_status.limit_hit),
        .o_valid (w_sh_valid),
        .o_quo   (w_sh_quo),
        .o_tag   (w_sh_inside)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (start) n_state = ST_MAP_IM;
            end
            ST_MAP_IM: begin
                n_state = ST_MAP_WAIT;
            end
            ST_MAP_WAIT: begin
                if (w_map_valid && w_map_tag.is_im) n_state = ST_ITER;
            end
            ST_ITER: begin
                if (w_esc_status.done) n_state = ST_SHADE;
            end
            ST_SHADE: begin
                if (w_sh_valid) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        busy           = (r_state != ST_IDLE);
        w_map_in_valid = ((r_state == ST_IDLE) && start) || (r_state == ST_MAP_IM);
        w_core_start   = (r_state == ST_MAP_WAIT) && w_map_valid && w_map_tag.is_im;
        w_sh_in_valid  = (r_state == ST_ITER) && w_esc_status.done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_shade_valid <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_shade_valid <= w_sh_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_sh_valid) begin
            r_shade <= w_sh_inside ? '0 : w_sh_quo;
        end
    end

    assign o_shade       = r_shade;
    assign o_shade_valid = r_shade_valid;

    // A shade is only shown right after the shade divider has finished.
    a_shade_after_divide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_shade_valid |-> $past(r_state == ST_SHADE))
        else $error("shade shown without a finished division");

    // Mapped coordinates only come out while the controller waits for them.
    a_map_out_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_map_valid |-> (r_state == ST_MAP_WAIT))
        else $error("coordinate left the division row outside the mapping phase");

    // The step loop only finishes while the controller is iterating.
    a_core_done_in_iter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_esc_status.done |-> (r_state == ST_ITER))
        else $error("escape loop finished outside the iteration phase");

    // The shade quotient only comes out while the controller waits for it.
    a_shade_out_in_shade: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sh_valid |-> (r_state == ST_SHADE))
        else $error("shade quotient left the division row unexpectedly");

endmodule

`default_nettype wire
